// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files; only dshot_frame_transmitter includes them.
// No dependencies; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge, off while reset is low.
`define DFT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Same, on the block's own clock and reset names.
`define DFT_ASSERT_I(label, prop, msg) \
  `DFT_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/dft_pkg.sv -----
// Types, codes and constants of the DShot frame transmitter.
// Used by the channel interfaces, the frame builder and the top level.
package dft_pkg;

  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [15:0] BitCyclesRst   = 16'd600;
  localparam logic [14:0] ShortHighRst   = 15'd200;

  localparam logic [10:0] CoefNormal     = 11'd1999;
  localparam logic [10:0] Coef3d         = 11'd999;
  localparam logic [13:0] OffsetLow      = 14'd48;
  localparam logic [13:0] Offset3dFwd    = 14'd1048;
  localparam logic [13:0] ValueLimit     = 14'd2048;

  typedef enum logic [1:0] {
    KIND_THROTTLE = 2'd0,
    KIND_COMMAND  = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_RSVD     = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE_3D    = 2'd0,
    CFG_BIT_CYCLES = 2'd1,
    CFG_SHORT_HIGH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] throttle;
    logic [5:0]         command;
    logic               telemetry_request;
  } req_item_t;

  typedef struct packed {
    logic                  line_level;
    logic                  busy_res;
    logic                  accepted;
    logic [FRAME_BITS-1:0] frame_word;
    logic                  frame_done;
  } res_item_t;

endpackage

// ----- rtl/dft_req_if.sv -----
// Request channel of the DShot frame transmitter: valid/ready plus item.
// Depends on dft_pkg.
interface dft_req_if import dft_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dft_res_if.sv -----
// Result channel of the DShot frame transmitter: valid/ready plus item.
// Depends on dft_pkg.
interface dft_res_if import dft_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dshot_frame_transmitter.sv -----
// DShot frame transmitter, one pin. Every request or tick item gives one result item; the
// item is worked combinationally and its result appears from an output register on the
// next edge, so items flow at one per clock while the result side takes them. The throttle
// multiplier and checksum in front of the state registers set the longest path.
// Depends on dft_pkg, dft_req_if, dft_res_if, dft_frame_build and assert_macros.svh.
`include "assert_macros.svh"

module dshot_frame_transmitter import dft_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  dft_req_if.sink             req_ch,
  dft_res_if.source           res_ch
);

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_HIGH = 2'd1,
    PH_TAIL = 2'd2
  } phase_e;

  // Configuration registers
  logic        mode_3d_q;
  logic [15:0] bit_cycles_q;
  logic [14:0] short_high_q;

  // Waveform state
  logic [FRAME_BITS-1:0] shift_q, shift_d;
  logic [3:0]            pos_q, pos_d;
  phase_e                phase_q, phase_d;
  logic [15:0]           pcount_q, pcount_d;
  logic                  sending_q, sending_d;

  logic      out_v_q;
  res_item_t res_q, res_d;

  logic                  acc;
  logic [FRAME_BITS-1:0] word;
  logic [14:0]           short_len;
  logic [15:0]           two_short;
  logic [15:0]           lead_len;
  logic [15:0]           phase_len;
  logic [15:0]           pcount_inc;
  logic                  is_request;

  assign req_ch.ready = !out_v_q || res_ch.ready;
  assign acc          = req_ch.valid && req_ch.ready;
  assign res_ch.valid = out_v_q;
  assign res_ch.data  = res_q;

  dft_frame_build u_build (
    .mode_3d_i     (mode_3d_q),
    .is_throttle_i (req_ch.data.kind == KIND_THROTTLE),
    .throttle_i    (req_ch.data.throttle),
    .command_i     (req_ch.data.command),
    .telem_i       (req_ch.data.telemetry_request),
    .word_o        (word)
  );

  assign short_len  = (short_high_q == '0) ? 15'd1 : short_high_q;
  assign two_short  = {short_len, 1'b0};
  assign lead_len   = (bit_cycles_q > two_short) ? bit_cycles_q - two_short : '0;
  assign phase_len  = (phase_q == PH_LEAD) ? lead_len : {1'b0, short_len};
  assign pcount_inc = pcount_q + 16'd1;
  assign is_request = req_ch.data.kind == KIND_THROTTLE || req_ch.data.kind == KIND_COMMAND;

  always_comb begin
    shift_d   = shift_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    pcount_d  = pcount_q;
    sending_d = sending_q;
    res_d     = '0;

    if (is_request) begin
      if (!sending_q) begin
        shift_d          = word;
        pos_d            = '0;
        phase_d          = (lead_len == '0) ? PH_HIGH : PH_LEAD;
        pcount_d         = '0;
        sending_d        = 1'b1;
        res_d.accepted   = 1'b1;
        res_d.frame_word = word;
      end
    end else if (req_ch.data.kind == KIND_TICK && sending_q) begin
      pcount_d = pcount_inc;
      if (pcount_inc >= phase_len) begin
        pcount_d = '0;
        unique case (phase_q)
          PH_LEAD: phase_d = PH_HIGH;
          PH_HIGH: phase_d = PH_TAIL;
          default: begin
            if (pos_q >= 4'(FRAME_BITS - 1)) begin
              sending_d        = 1'b0;
              phase_d          = PH_LEAD;
              pos_d            = '0;
              shift_d          = '0;
              res_d.frame_done = 1'b1;
            end else begin
              pos_d   = pos_q + 4'd1;
              shift_d = {shift_q[FRAME_BITS-2:0], 1'b0};
              phase_d = (lead_len == '0) ? PH_HIGH : PH_LEAD;
            end
          end
        endcase
      end
    end

    res_d.busy_res = sending_d;
    if (!sending_d || phase_d == PH_LEAD) begin
      res_d.line_level = 1'b0;
    end else if (phase_d == PH_HIGH) begin
      res_d.line_level = 1'b1;
    end else begin
      res_d.line_level = shift_d[FRAME_BITS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_3d_q    <= 1'b0;
      bit_cycles_q <= BitCyclesRst;
      short_high_q <= ShortHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE_3D:    mode_3d_q    <= cfg_wdata_i[0];
        CFG_BIT_CYCLES: bit_cycles_q <= cfg_wdata_i;
        CFG_SHORT_HIGH: short_high_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      pos_q     <= '0;
      phase_q   <= PH_LEAD;
      pcount_q  <= '0;
      sending_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (acc) begin
        shift_q   <= shift_d;
        pos_q     <= pos_d;
        phase_q   <= phase_d;
        pcount_q  <= pcount_d;
        sending_q <= sending_d;
        out_v_q   <= 1'b1;
      end else if (res_ch.ready) begin
        out_v_q   <= 1'b0;
      end
    end
  end

  // result payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
    end
  end

  `DFT_ASSERT(a_idle_clean, clk_i, rst_ni,
              !sending_q |-> (phase_q == PH_LEAD && pos_q == '0 && shift_q == '0),
              "idle with stale waveform state")
  `DFT_ASSERT(a_take_busy, clk_i, rst_ni,
              out_v_q && res_q.accepted |-> res_q.busy_res,
              "request taken but not busy")
  `DFT_ASSERT(a_done_low, clk_i, rst_ni,
              out_v_q && res_q.frame_done |-> (!res_q.busy_res && !res_q.line_level),
              "frame end with line high or busy")
  `DFT_ASSERT(a_stall_block, clk_i, rst_ni,
              out_v_q && !res_ch.ready |-> !req_ch.ready,
              "new transaction taken over a pending result")

endmodule

// ----- rtl/dft_frame_build.sv -----
// Frame builder: throttle to DShot value mapping, telemetry bit, checksum.
// Depends on dft_pkg. Purely combinational.
module dft_frame_build import dft_pkg::*; (
  input  logic                  mode_3d_i,
  input  logic                  is_throttle_i,
  input  logic signed [15:0]    throttle_i,
  input  logic [5:0]            command_i,
  input  logic                  telem_i,
  output logic [FRAME_BITS-1:0] word_o
);

  logic        neg;
  logic [15:0] mag;
  logic [10:0] coef;
  logic [13:0] offset;
  logic [26:0] prod;
  logic [13:0] val;
  logic [10:0] thr_value;
  logic [10:0] value;
  logic [11:0] pt;
  logic [3:0]  csum;

  assign neg    = throttle_i[15];
  assign mag    = neg ? 16'(~throttle_i + 16'sd1) : 16'(throttle_i);
  assign coef   = mode_3d_i ? Coef3d : CoefNormal;
  assign offset = (mode_3d_i && !neg) ? Offset3dFwd : OffsetLow;
  assign prod   = {11'd0, mag} * {16'd0, coef};
  assign val    = {1'b0, prod[26:14]} + offset;

  always_comb begin
    if (!mode_3d_i && neg) begin
      thr_value = '0;
    end else if (val < OffsetLow || val >= ValueLimit) begin
      thr_value = '0;
    end else begin
      thr_value = val[10:0];
    end
  end

  assign value  = is_throttle_i ? thr_value : {5'd0, command_i};
  assign pt     = {value, telem_i};
  assign csum   = pt[3:0] ^ pt[7:4] ^ pt[11:8];
  assign word_o = {pt, csum};

endmodule
